@@ sv/cscomp_pkg.sv @@
// ============================================================================
// cscomp_pkg
// Shared constants and types for the climate sensor compensation pipeline.
// ============================================================================
`default_nettype none

package cscomp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_TEMP    = 3'd0,
        CFG_CAL_PRESS_A = 3'd1,
        CFG_CAL_PRESS_B = 3'd2,
        CFG_CAL_PRESS_C = 3'd3,
        CFG_CAL_HUM     = 3'd4
    } t_cfg_idx;

    // Divider: one quotient bit per stage over a 64-bit dividend.
    localparam int DIV_W     = 64;
    localparam int DIVISOR_W = 31;

    // Stages ahead of the divider and behind it.
    localparam int PRE_STG  = 11;
    localparam int POST_STG = 6;
    localparam int N_STG    = PRE_STG + DIV_W + POST_STG;

    localparam logic [33:0] TF_PRESS_OFFS = 34'd128000;
    localparam logic [31:0] TF_HUM_OFFS   = 32'd76800;
    localparam logic [20:0] PRESS_BASE    = 21'd1048576;
    localparam logic [63:0] PRESS_SCALE   = 64'd3125;
    localparam logic [31:0] HUM_W_OFFS    = 32'd2097152;
    localparam logic [31:0] HUM_MAX       = 32'd419430400;

    typedef struct packed {
        logic [DIVISOR_W-1:0] rem;
        logic [DIV_W-1:0]     dq;
        logic [DIVISOR_W-1:0] mb;
        logic                 neg;
        logic                 inv;
    } t_div_stage;

endpackage

`default_nettype wire

@@ sv/climate_sensor_compensation.sv @@
// ============================================================================
// climate_sensor_compensation
// Fixed-point temperature, pressure and humidity compensation pipeline.
// ============================================================================
// Usage: an item (one raw temperature, pressure and humidity triple) is taken
// at every rising edge where i_start is high; o_busy is always low, so one
// item may enter in every cycle. Each item yields exactly one result, shown
// on the output ports for one cycle with o_done high. Results leave in the
// order the items came in. The signed pressure divider (64-bit dividend)
// resolves one quotient bit per stage (64 stages), with 11 stages before
// it and 6 after. The calibration registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_wdata; the user must write them only while no item
// is in flight, as the block itself does not enforce it. Writes to unknown
// indexes are dropped. Reset clears the calibration registers and all valid
// bits. The receiver cannot stall, so there is no back pressure.
// ============================================================================
`default_nettype none

module climate_sensor_compensation (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [19:0]                         i_raw_temperature,
    input  wire logic [19:0]                         i_raw_pressure,
    input  wire logic [15:0]                         i_raw_humidity,
    input  wire logic                                i_cfg_we,
    input  wire logic [cscomp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cscomp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                                     o_done,
    output logic signed [31:0]                       o_temperature_centi,
    output logic [31:0]                              o_pressure_q24_8,
    output logic [16:0]                              o_humidity_q22_10,
    output logic                                     o_pressure_invalid
);
    import cscomp_pkg::*;

    localparam int TEMP_DLY = N_STG - 6;
    localparam int HUM_DLY  = N_STG - 16;

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_pa;
    logic [63:0] r_cal_pb;
    logic [15:0] r_cal_pc;
    logic [63:0] r_cal_h;
    logic [N_STG:1] r_vld;

    // Calibration fields.
    logic [15:0] t1;
    logic [31:0] t2x, t3x;
    logic [15:0] p1;
    logic signed [15:0] p2, p5;
    logic [63:0] p3x, p4x, p6x, p8x, p9x;
    logic [31:0] p7x;
    logic [31:0] h1x, h2x, h3x, h4x, h5x, h6x;

    assign t1  = r_cal_temp[15:0];
    assign t2x = {{16{r_cal_temp[31]}}, r_cal_temp[31:16]};
    assign t3x = {{16{r_cal_temp[47]}}, r_cal_temp[47:32]};
    assign p1  = r_cal_pa[15:0];
    assign p2  = r_cal_pa[31:16];
    assign p3x = {{48{r_cal_pa[47]}}, r_cal_pa[47:32]};
    assign p4x = {{48{r_cal_pa[63]}}, r_cal_pa[63:48]};
    assign p5  = r_cal_pb[15:0];
    assign p6x = {{48{r_cal_pb[31]}}, r_cal_pb[31:16]};
    assign p7x = {{16{r_cal_pb[47]}}, r_cal_pb[47:32]};
    assign p8x = {{48{r_cal_pb[63]}}, r_cal_pb[63:48]};
    assign p9x = {{48{r_cal_pc[15]}}, r_cal_pc};
    assign h1x = {24'd0, r_cal_h[7:0]};
    assign h2x = {{16{r_cal_h[23]}}, r_cal_h[23:8]};
    assign h3x = {24'd0, r_cal_h[31:24]};
    assign h4x = {{20{r_cal_h[43]}}, r_cal_h[43:32]};
    assign h5x = {{20{r_cal_h[55]}}, r_cal_h[55:44]};
    assign h6x = {{24{r_cal_h[63]}}, r_cal_h[63:56]};

    // Temperature stages.
    logic [31:0] r1_d1, r1_d2, r2_m1, r2_m2, r3_v1, r3_a, r4_tf;
    logic [19:0] r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp, r8_rp;
    logic [15:0] r1_rh, r2_rh, r3_rh, r4_rh, r5_rh, r6_rh;
    logic signed [31:0] r5_temp;
    logic signed [33:0] r5_w1;
    logic [31:0] r5_v;

    // Pressure stages ahead of the divider.
    logic [63:0] r6_sq;
    logic signed [49:0] r6_wp5, r6_wp2;
    logic [63:0] r7_a, r7_b, r7_c5, r7_c2;
    logic [63:0] r8_w2, r8_w1n;
    logic [63:0] r9_x1, r9_n1;
    logic signed [DIVISOR_W-1:0] r10_div;
    logic [63:0] r10_n;
    logic r10_inv;
    t_div_stage r_dv [DIV_W+1];

    // Pressure stages behind the divider.
    logic [63:0] r76_q, r77_q, r77_x, r77_e2p, r78_q, r78_ll, r78_e2, r79_s, r79_e1, r80_s2;
    logic [31:0] r78_lh, r78_hl;
    logic r76_inv, r77_inv, r78_inv, r79_inv, r80_inv;

    // Humidity stages.
    logic [31:0] r6_m5, r6_y0, r6_z0, r7_x, r7_y, r7_z, r8_x, r8_yz, r9_x, r9_w;
    logic [31:0] r10_x, r10_wm, r11_x, r11_w, r12_v, r13_v, r13_ss, r14_v, r14_k;
    logic [16:0] r15_hum;

    logic [31:0] r_td [TEMP_DLY];
    logic [16:0] r_hd [HUM_DLY];

    // Next values.
    logic [31:0] n1_d1, n1_d2, n5_tsum;
    logic signed [31:0] n3_m2s;
    logic signed [67:0] n6_sq;
    logic signed [49:0] n6_wp5, n6_wp2;
    logic [20:0] n9_pr;
    logic [63:0] n11_ma;
    logic [DIVISOR_W-1:0] n11_mb;
    logic [63:0] n77_ps, n78_ps, n81_s2sh;
    logic [31:0] n7_hsum, n15_v, n15_vc;

    assign n1_d1   = ({12'd0, i_raw_temperature} >> 3) - ({16'd0, t1} << 1);
    assign n1_d2   = ({12'd0, i_raw_temperature} >> 4) - {16'd0, t1};
    assign n3_m2s  = $signed(r2_m2) >>> 12;
    assign n5_tsum = r4_tf * 32'd5 + 32'd128;
    assign n6_sq   = r5_w1 * r5_w1;
    assign n6_wp5  = r5_w1 * p5;
    assign n6_wp2  = r5_w1 * p2;
    assign n9_pr   = PRESS_BASE - {1'b0, r8_rp};
    assign n11_ma  = r10_n[63] ? (64'd0 - r10_n) : r10_n;
    assign n11_mb  = r10_div[DIVISOR_W-1] ? (DIVISOR_W'(0) - r10_div) : r10_div;
    assign n77_ps  = $signed(r76_q) >>> 13;
    assign n78_ps  = $signed(r77_q) >>> 13;
    assign n81_s2sh = $signed(r80_s2) >>> 8;
    assign n7_hsum = ({16'd0, r6_rh} << 14) - (h4x << 20) - r6_m5 + 32'd16384;
    assign n15_v   = r14_v - 32'($signed(r14_k) >>> 4);

    always_comb begin
        if (n15_v[31]) begin
            n15_vc = '0;
        end else if (n15_v > HUM_MAX) begin
            n15_vc = HUM_MAX;
        end else begin
            n15_vc = n15_v;
        end
    end

    function automatic t_div_stage div_step(input t_div_stage s);
        logic [DIVISOR_W:0] t;
        t_div_stage         o;
        t = {s.rem, s.dq[DIV_W-1]};
        o = s;
        if (t >= {1'b0, s.mb}) begin
            o.rem = DIVISOR_W'(t - {1'b0, s.mb});
            o.dq  = {s.dq[DIV_W-2:0], 1'b1};
        end else begin
            o.rem = t[DIVISOR_W-1:0];
            o.dq  = {s.dq[DIV_W-2:0], 1'b0};
        end
        return o;
    endfunction

    assign o_busy = 1'b0;
    assign o_done = r_vld[N_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_cal_temp <= '0;
            r_cal_pa   <= '0;
            r_cal_pb   <= '0;
            r_cal_pc   <= '0;
            r_cal_h    <= '0;
        end else begin
            r_vld <= {r_vld[N_STG-1:1], i_start};
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CAL_TEMP:    r_cal_temp <= i_cfg_wdata[47:0];
                    CFG_CAL_PRESS_A: r_cal_pa   <= i_cfg_wdata;
                    CFG_CAL_PRESS_B: r_cal_pb   <= i_cfg_wdata;
                    CFG_CAL_PRESS_C: r_cal_pc   <= i_cfg_wdata[15:0];
                    CFG_CAL_HUM:     r_cal_h    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Temperature and fine temperature.
        r1_d1 <= n1_d1;
        r1_d2 <= n1_d2;
        r1_rp <= i_raw_pressure;
        r1_rh <= i_raw_humidity;
        r2_m1 <= r1_d1 * t2x;
        r2_m2 <= r1_d2 * r1_d2;
        r2_rp <= r1_rp;
        r2_rh <= r1_rh;
        r3_v1 <= 32'($signed(r2_m1) >>> 11);
        r3_a  <= n3_m2s * t3x;
        r3_rp <= r2_rp;
        r3_rh <= r2_rh;
        r4_tf <= r3_v1 + 32'($signed(r3_a) >>> 14);
        r4_rp <= r3_rp;
        r4_rh <= r3_rh;
        r5_temp <= $signed(n5_tsum) >>> 8;
        r5_w1   <= $signed({{2{r4_tf[31]}}, r4_tf}) - $signed(TF_PRESS_OFFS);
        r5_v    <= r4_tf - TF_HUM_OFFS;
        r5_rp   <= r4_rp;
        r5_rh   <= r4_rh;

        // Pressure, ahead of the divider.
        r6_sq  <= n6_sq[63:0];
        r6_wp5 <= n6_wp5;
        r6_wp2 <= n6_wp2;
        r6_rp  <= r5_rp;
        r6_rh  <= r5_rh;
        r7_a   <= r6_sq * p6x;
        r7_b   <= r6_sq * p3x;
        r7_c5  <= {{14{r6_wp5[49]}}, r6_wp5} << 17;
        r7_c2  <= {{14{r6_wp2[49]}}, r6_wp2} << 12;
        r7_rp  <= r6_rp;
        r8_w2  <= r7_a + r7_c5 + (p4x << 35);
        r8_w1n <= 64'($signed(r7_b) >>> 8) + r7_c2;
        r8_rp  <= r7_rp;
        r9_x1  <= (64'h0000_8000_0000_0000 + r8_w1n) * {48'd0, p1};
        r9_n1  <= ({43'd0, n9_pr} << 31) - r8_w2;
        r10_div <= r9_x1[63:33];
        r10_n   <= r9_n1 * PRESS_SCALE;
        r10_inv <= (r9_x1[63:33] == '0);

        r_dv[0].rem <= '0;
        r_dv[0].dq  <= n11_ma;
        r_dv[0].mb  <= n11_mb;
        r_dv[0].neg <= r10_n[63] ^ r10_div[DIVISOR_W-1];
        r_dv[0].inv <= r10_inv;
        for (int k = 0; k < DIV_W; k++) begin
            r_dv[k+1] <= div_step(r_dv[k]);
        end

        // Pressure, behind the divider.
        r76_q   <= r_dv[DIV_W].neg ? (64'd0 - r_dv[DIV_W].dq) : r_dv[DIV_W].dq;
        r76_inv <= r_dv[DIV_W].inv;
        r77_q   <= r76_q;
        r77_x   <= n77_ps * p9x;
        r77_e2p <= r76_q * p8x;
        r77_inv <= r76_inv;
        r78_q   <= r77_q;
        r78_ll  <= {32'd0, r77_x[31:0]} * {32'd0, n78_ps[31:0]};
        r78_lh  <= r77_x[31:0] * n78_ps[63:32];
        r78_hl  <= r77_x[63:32] * n78_ps[31:0];
        r78_e2  <= $signed(r77_e2p) >>> 19;
        r78_inv <= r77_inv;
        r79_s   <= r78_q + r78_e2;
        r79_e1  <= $signed(r78_ll + {r78_lh + r78_hl, 32'd0}) >>> 25;
        r79_inv <= r78_inv;
        r80_s2  <= r79_s + r79_e1;
        r80_inv <= r79_inv;

        // Humidity.
        r6_m5  <= h5x * r5_v;
        r6_y0  <= r5_v * h6x;
        r6_z0  <= r5_v * h3x;
        r7_x   <= $signed(n7_hsum) >>> 15;
        r7_y   <= $signed(r6_y0) >>> 10;
        r7_z   <= 32'($signed(r6_z0) >>> 11) + 32'd32768;
        r8_x   <= r7_x;
        r8_yz  <= r7_y * r7_z;
        r9_x   <= r8_x;
        r9_w   <= 32'($signed(r8_yz) >>> 10) + HUM_W_OFFS;
        r10_x  <= r9_x;
        r10_wm <= r9_w * h2x;
        r11_x  <= r10_x;
        r11_w  <= $signed(r10_wm + 32'd8192) >>> 14;
        r12_v  <= r11_x * r11_w;
        r13_v  <= r12_v;
        r13_ss <= 32'($signed(r12_v) >>> 15) * 32'($signed(r12_v) >>> 15);
        r14_v  <= r13_v;
        r14_k  <= 32'($signed(r13_ss) >>> 7) * h1x;
        r15_hum <= n15_vc[28:12];

        // Alignment of temperature and humidity with pressure.
        r_td[0] <= r5_temp;
        for (int k = 1; k < TEMP_DLY; k++) begin
            r_td[k] <= r_td[k-1];
        end
        r_hd[0] <= r15_hum;
        for (int k = 1; k < HUM_DLY; k++) begin
            r_hd[k] <= r_hd[k-1];
        end

        o_temperature_centi <= r_td[TEMP_DLY-1];
        o_humidity_q22_10   <= r_hd[HUM_DLY-1];
        o_pressure_invalid  <= r80_inv;
        o_pressure_q24_8    <= r80_inv ? 32'd0 : (n81_s2sh[31:0] + (p7x << 4));
    end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ============================================================================
// tb
// Testbench for the climate sensor compensation pipeline.
// ============================================================================
// Items are driven on the falling edge in random bursts. A scoreboard class
// computes the compensated temperature, pressure and humidity for each item
// and checks every result in order. Calibration is changed between phases
// once the pipeline has drained.
// ============================================================================
`default_nettype none

class comp_scoreboard;
    logic [47:0] cal_temp;
    logic [63:0] cal_pa;
    logic [63:0] cal_pb;
    logic [15:0] cal_pc;
    logic [63:0] cal_hum;
    logic [31:0] want_temp[$];
    logic [31:0] want_press[$];
    logic [16:0] want_hum[$];
    logic        want_inv[$];
    int          errors;

    function new();
        cal_temp = '0;
        cal_pa = '0;
        cal_pb = '0;
        cal_pc = '0;
        cal_hum = '0;
        errors = 0;
    endfunction

    function void set_reg(cscomp_pkg::t_cfg_idx idx, logic [63:0] val);
        case (idx)
            cscomp_pkg::CFG_CAL_TEMP:    cal_temp = val[47:0];
            cscomp_pkg::CFG_CAL_PRESS_A: cal_pa = val;
            cscomp_pkg::CFG_CAL_PRESS_B: cal_pb = val;
            cscomp_pkg::CFG_CAL_PRESS_C: cal_pc = val[15:0];
            cscomp_pkg::CFG_CAL_HUM:     cal_hum = val;
            default: ;
        endcase
    endfunction

    function void note_item(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        logic signed [31:0] t1, t2, t3, d1, d2, v1, v2, tf, temp;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, ps, e1, e2;
        logic signed [63:0] num, press;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w, s;
        logic inv;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        d1 = {15'd0, rt[19:3]} - (t1 <<< 1);
        v1 = (d1 * t2) >>> 11;
        d2 = {16'd0, rt[19:4]} - t1;
        v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        temp = (tf * 5 + 128) >>> 8;

        p1 = {48'd0, cal_pa[15:0]};
        p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
        p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
        p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
        p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
        p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
        p9 = {{48{cal_pc[15]}}, cal_pc};
        w1 = {{32{tf[31]}}, tf} - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        press = 0;
        inv = (w1 == 0);
        if (!inv) begin
            p = 64'sd1048576 - {44'd0, rp};
            num = ((p <<< 31) - w2) * 64'sd3125;
            if (num == 64'sh8000000000000000 && w1 == -64'sd1) p = num;
            else p = num / w1;
            ps = p >>> 13;
            e1 = (p9 * ps * ps) >>> 25;
            e2 = (p8 * p) >>> 19;
            press = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
        end

        h1 = {24'd0, cal_hum[7:0]};
        h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
        h3 = {24'd0, cal_hum[31:24]};
        h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
        h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
        h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
        v = tf - 32'sd76800;
        x = (($signed({16'd0, rh}) <<< 14) - (h4 <<< 20) - h5 * v + 32'sd16384) >>> 15;
        y = (v * h6) >>> 10;
        z = ((v * h3) >>> 11) + 32'sd32768;
        w = ((y * z) >>> 10) + 32'sd2097152;
        w = (w * h2 + 32'sd8192) >>> 14;
        v = x * w;
        s = v >>> 15;
        v = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0) v = 0;
        else if (v > 32'sd419430400) v = 32'sd419430400;

        want_temp.push_back(temp);
        want_press.push_back(press[31:0]);
        want_hum.push_back(v[28:12]);
        want_inv.push_back(inv);
    endfunction

    function void check_result(logic [31:0] t, logic [31:0] p, logic [16:0] h,
                               logic inv);
        logic [31:0] et, ep;
        logic [16:0] eh;
        logic ei;
        if (want_temp.size() == 0) begin
            $error("unexpected result");
            errors++;
            return;
        end
        et = want_temp.pop_front();
        ep = want_press.pop_front();
        eh = want_hum.pop_front();
        ei = want_inv.pop_front();
        if (t !== et) begin
            $error("temperature_centi exp %0h got %0h", et, t);
            errors++;
        end
        if (p !== ep) begin
            $error("pressure_q24_8 exp %0h got %0h", ep, p);
            errors++;
        end
        if (h !== eh) begin
            $error("humidity_q22_10 exp %0h got %0h", eh, h);
            errors++;
        end
        if (inv !== ei) begin
            $error("pressure_invalid exp %0h got %0h", ei, inv);
            errors++;
        end
    endfunction

    function int pending();
        return want_temp.size();
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cscomp_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic [15:0] i_raw_humidity = '0;
    logic        i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        o_busy, o_done, o_pressure_invalid;
    logic [31:0] o_temperature_centi, o_pressure_q24_8;
    logic [16:0] o_humidity_q22_10;

    comp_scoreboard sb = new();
    int cycles = 0;

    climate_sensor_compensation dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_done)
            sb.check_result(o_temperature_centi, o_pressure_q24_8, o_humidity_q22_10,
                            o_pressure_invalid);
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Calls at the falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                             bit hold);
        i_start = 1;
        i_raw_temperature = rt;
        i_raw_pressure = rp;
        i_raw_humidity = rh;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_item(rt, rp, rh);
        @(negedge i_clk);
        if (!hold) i_start = 0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (N_STG + 5) @(negedge i_clk);
    endtask

    task automatic random_phase(int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++)
                send_item(20'($urandom_range(0, 20'hFFFFF)),
                          20'($urandom_range(0, 20'hFFFFF)),
                          16'($urandom_range(0, 16'hFFFF)), k != burst - 1);
            left -= burst;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        drain();
    endtask

    // Typical sensor calibration words.
    localparam logic [63:0] TYP_T  = {16'd0, 16'sd50, 16'sd26435, 16'd27504};
    localparam logic [63:0] TYP_PA = {16'sd2855, -16'sd3024, 16'sd2816, 16'd36477} ;
    localparam logic [63:0] TYP_PB = {-16'sd10230, 16'sd15500, -16'sd7, 16'sd140};
    localparam logic [63:0] TYP_H  = {8'sd30, 12'sd50, 12'sd312, 8'd0, 16'sd361, 8'd75};

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        // Reset calibration: zero pressure divisor.
        send_item(20'h80000, 20'h60000, 16'h7000, 0);
        drain();
        write_reg(CFG_CAL_TEMP, TYP_T);
        write_reg(CFG_CAL_PRESS_A, TYP_PA);
        write_reg(CFG_CAL_PRESS_B, TYP_PB);
        write_reg(CFG_CAL_PRESS_C, 64'd6000);
        write_reg(CFG_CAL_HUM, TYP_H);
        @(negedge i_clk);
        send_item(20'h0, 20'h0, 16'h0, 1);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1);
        send_item(20'h84000, 20'h5A000, 16'h6B00, 1);
        send_item(20'h0, 20'hFFFFF, 16'h0, 1);
        send_item(20'hFFFFF, 20'h0, 16'hFFFF, 1);
        send_item(20'h7F000, 20'h50000, 16'h8000, 0);
        drain();
        random_phase(400);
        // Extremes of every register.
        write_reg(CFG_CAL_TEMP, 64'hFFFF_FFFF_FFFF);
        write_reg(CFG_CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CAL_PRESS_C, 64'hFFFF);
        write_reg(CFG_CAL_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(20'h0, 20'h0, 16'h0, 1);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
        drain();
        write_reg(CFG_CAL_TEMP, 64'h8000_8000_FFFF);
        write_reg(CFG_CAL_PRESS_A, 64'h7FFF_8000_7FFF_FFFF);
        write_reg(CFG_CAL_PRESS_B, 64'h8000_7FFF_8000_7FFF);
        write_reg(CFG_CAL_PRESS_C, 64'h8000);
        write_reg(CFG_CAL_HUM, 64'h8080_0800_FF80_00FF);
        send_item(20'h0, 20'h0, 16'h0, 1);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
        drain();
        random_phase(100);
        for (int r = 0; r < 5; r++) begin
            write_reg(t_cfg_idx'(r), {$urandom, $urandom});
        end
        random_phase(200);
        write_reg(CFG_CAL_TEMP, TYP_T ^ {48'd0, 16'($urandom_range(0, 255))});
        write_reg(CFG_CAL_PRESS_A, TYP_PA);
        write_reg(CFG_CAL_PRESS_B, TYP_PB);
        write_reg(CFG_CAL_HUM, TYP_H);
        random_phase(330);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
